/* src/vn_pkg.sv */
// vn_pkg: shared types and default sizes for the vector normalizer
// no dependencies
`timescale 1ns / 1ps

package vn_pkg;

  localparam int unsigned DefCoordWidth = 16;
  localparam int unsigned DefFracBits   = 14;
  localparam int unsigned NumLanes      = 3;

  // control that rides along with every pipeline stage
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } ctl_t;

endpackage

/* src/vn_if.sv */
// vn_in_if / vn_out_if: valid-ready channels for vertices and unit vectors
// depends on nothing but the coordinate width parameter
`timescale 1ns / 1ps

interface vn_in_if #(parameter int unsigned CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [CW-1:0] z_in;
  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vn_out_if #(parameter int unsigned CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_unit;
  logic signed [CW-1:0] y_unit;
  logic signed [CW-1:0] z_unit;
  logic                 zero_vector;
  modport source (output valid, x_unit, y_unit, z_unit, zero_vector, input ready);
  modport sink   (input valid, x_unit, y_unit, z_unit, zero_vector, output ready);
endinterface

/* src/vector3_normalize.sv */
// vector3_normalize: top level, streams vertices to unit vectors
// depends on vn_pkg, vn_if, vn_sqsum and vn_root_step
`timescale 1ns / 1ps

// Accepts one vertex per cycle while the output is not stalled and returns one
// unit vector per vertex, in order. Three stages form the sum of squares, then
// one add-and-compare stage per quotient bit (FRAC_BITS + 1 of them) finds the
// rounded quotient, and a last stage applies the sign and saturation. A zero
// vertex returns zero components with zero_vector set. When the output is
// stalled the whole pipeline holds; in_ch.ready is low only then.

module vector3_normalize import vn_pkg::*; #(
  parameter int unsigned COORD_WIDTH = DefCoordWidth,
  parameter int unsigned FRAC_BITS   = DefFracBits
) (
  input  logic    clk,
  input  logic    rst_n,
  vn_in_if.sink   in_ch,
  vn_out_if.source out_ch
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned W  = 2 * CW + 2 * F + 6;
  localparam int unsigned QW = F + 2;
  localparam int unsigned QX = CW + F + 3;
  localparam int unsigned NS = F + 1;

  logic                 en;
  logic                 out_valid_r;
  logic signed [CW-1:0] unit_r [NumLanes];
  logic                 zero_r;
  logic signed [CW-1:0] unit_nxt [NumLanes];
  logic signed [CW-1:0] coord [NumLanes];

  ctl_t                 ctl_s [NS+1];
  logic signed [W-1:0]  sum_s [NS+1];
  logic signed [W-1:0]  tgt_s [NS+1][NumLanes];
  logic signed [W-1:0]  acc_s [NS+1][NumLanes];
  logic signed [W-1:0]  lin_s [NS+1][NumLanes];
  logic [QW-1:0]        q_s   [NS+1][NumLanes];

  logic [QX-1:0] maxpos;
  logic [QX-1:0] qx;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign coord[0]    = in_ch.x_in;
  assign coord[1]    = in_ch.y_in;
  assign coord[2]    = in_ch.z_in;

  vn_sqsum #(.CW(CW), .F(F), .W(W)) u_sqsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (in_ch.valid),
    .coord    (coord),
    .ctl_out  (ctl_s[0]),
    .sum_out  (sum_s[0]),
    .tgt_out  (tgt_s[0])
  );

  // search starts at q = 0, so 2q-1 = -1
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      acc_s[0][i] = sum_s[0];
      lin_s[0][i] = -sum_s[0];
      q_s[0][i]   = '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    vn_root_step #(.CW(CW), .F(F), .W(W), .QW(QW), .BIT(F - k)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (ctl_s[k]),
      .sum_in  (sum_s[k]),
      .tgt_in  (tgt_s[k]),
      .acc_in  (acc_s[k]),
      .lin_in  (lin_s[k]),
      .q_in    (q_s[k]),
      .ctl_out (ctl_s[k+1]),
      .sum_out (sum_s[k+1]),
      .tgt_out (tgt_s[k+1]),
      .acc_out (acc_s[k+1]),
      .lin_out (lin_s[k+1]),
      .q_out   (q_s[k+1])
    );
  end

  assign maxpos = {{(QX - CW + 1){1'b0}}, {(CW - 1){1'b1}}};

  always_comb begin
    qx = '0;
    for (int i = 0; i < NumLanes; i++) begin
      qx = QX'(q_s[NS][i]);
      if (ctl_s[NS].zero) begin
        unit_nxt[i] = '0;
      end else if (ctl_s[NS].neg[i]) begin
        if (qx > maxpos + 1'b1) qx = maxpos + 1'b1;
        unit_nxt[i] = ~qx[CW-1:0] + 1'b1;
      end else begin
        if (qx > maxpos) qx = maxpos;
        unit_nxt[i] = qx[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_s[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      zero_r <= ctl_s[NS].zero;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_unit      = unit_r[0];
  assign out_ch.y_unit      = unit_r[1];
  assign out_ch.z_unit      = unit_r[2];
  assign out_ch.zero_vector = zero_r;

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> unit_r[0] == '0 && unit_r[1] == '0 && unit_r[2] == '0)
    else $error("zero vector transaction with nonzero components");

  a_nonzero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !zero_r |-> unit_r[0] != '0 || unit_r[1] != '0 || unit_r[2] != '0)
    else $error("nonzero vector normalized to all zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

endmodule

/* src/vn_sqsum.sv */
// vn_sqsum: magnitude, squares and sum of squares, three register stages
// depends on vn_pkg
`timescale 1ns / 1ps

module vn_sqsum import vn_pkg::*; #(
  parameter int unsigned CW = DefCoordWidth,
  parameter int unsigned F  = DefFracBits,
  parameter int unsigned W  = 2 * CW + 2 * F + 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [CW-1:0] coord [NumLanes],
  output ctl_t                 ctl_out,
  output logic signed [W-1:0]  sum_out,
  output logic signed [W-1:0]  tgt_out [NumLanes]
);

  ctl_t                ctl1_r, ctl2_r, ctl3_r;
  logic [CW-1:0]       mag_r [NumLanes];
  logic [2*CW-1:0]     sq_r  [NumLanes];
  logic signed [W-1:0] sum_r;
  logic signed [W-1:0] tgt_r [NumLanes];
  ctl_t                ctl1_nxt;
  logic [CW-1:0]       mag_nxt [NumLanes];

  always_comb begin
    ctl1_nxt.valid = valid_in;
    for (int i = 0; i < NumLanes; i++) begin
      ctl1_nxt.neg[i] = coord[i][CW-1];
      mag_nxt[i] = coord[i][CW-1] ? (~coord[i] + 1'b1) : coord[i];
    end
    ctl1_nxt.zero = (coord[0] == '0) && (coord[1] == '0) && (coord[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NumLanes; i++) begin
        mag_r[i] <= mag_nxt[i];
        sq_r[i]  <= mag_r[i] * mag_r[i];
        tgt_r[i] <= W'(sq_r[i]) << (2 * F + 2);
      end
      sum_r <= W'(sq_r[0]) + W'(sq_r[1]) + W'(sq_r[2]);
    end
  end

  assign ctl_out = ctl3_r;
  assign sum_out = sum_r;
  assign tgt_out = tgt_r;

endmodule

/* src/vn_root_step.sv */
// vn_root_step: one quotient bit of the rounded length division, all three lanes
// depends on vn_pkg
`timescale 1ns / 1ps

module vn_root_step import vn_pkg::*; #(
  parameter int unsigned CW  = DefCoordWidth,
  parameter int unsigned F   = DefFracBits,
  parameter int unsigned W   = 2 * CW + 2 * F + 6,
  parameter int unsigned QW  = F + 2,
  parameter int unsigned BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic signed [W-1:0]  sum_in,
  input  logic signed [W-1:0]  tgt_in [NumLanes],
  input  logic signed [W-1:0]  acc_in [NumLanes],
  input  logic signed [W-1:0]  lin_in [NumLanes],
  input  logic [QW-1:0]        q_in   [NumLanes],
  output ctl_t                 ctl_out,
  output logic signed [W-1:0]  sum_out,
  output logic signed [W-1:0]  tgt_out [NumLanes],
  output logic signed [W-1:0]  acc_out [NumLanes],
  output logic signed [W-1:0]  lin_out [NumLanes],
  output logic [QW-1:0]        q_out   [NumLanes]
);

  // acc = (2q-1)^2 * S, lin = (2q-1) * S
  ctl_t                ctl_r;
  logic signed [W-1:0] sum_r;
  logic signed [W-1:0] tgt_r [NumLanes];
  logic signed [W-1:0] acc_r [NumLanes];
  logic signed [W-1:0] lin_r [NumLanes];
  logic [QW-1:0]       q_r   [NumLanes];
  logic signed [W-1:0] trial [NumLanes];
  logic                take  [NumLanes];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      trial[i] = acc_in[i] + (lin_in[i] <<< (BIT + 2)) + (sum_in <<< (2 * BIT + 2));
      take[i]  = trial[i] <= tgt_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_in;
      for (int i = 0; i < NumLanes; i++) begin
        tgt_r[i] <= tgt_in[i];
        if (take[i]) begin
          acc_r[i] <= trial[i];
          lin_r[i] <= lin_in[i] + (sum_in <<< (BIT + 1));
          q_r[i]   <= q_in[i] | (QW'(1) << BIT);
        end else begin
          acc_r[i] <= acc_in[i];
          lin_r[i] <= lin_in[i];
          q_r[i]   <= q_in[i];
        end
      end
    end
  end

  assign ctl_out = ctl_r;
  assign sum_out = sum_r;
  assign tgt_out = tgt_r;
  assign acc_out = acc_r;
  assign lin_out = lin_r;
  assign q_out   = q_r;

endmodule
